// ----- rtl/fbvs_pkg.sv -----
`default_nettype none

package fbvs_pkg;

    // Bone table geometry
    localparam int NUM_BONES      = 64;
    localparam int BONE_W         = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
    localparam int WORDS_PER_BONE = 12;
    localparam int TABLE_WORDS    = NUM_BONES * WORDS_PER_BONE;
    localparam int INFLUENCES     = 4;
    localparam int ROWS           = 3;
    localparam int COLS           = 3;

    // Field widths
    localparam int ADDR_W   = 10;
    localparam int WORD_W   = 32;
    localparam int INFL_W   = 22;
    localparam int INDEX_W  = 6;
    localparam int WEIGHT_W = 16;

    // Input tdata layout, lowest bit first
    localparam int LOAD_ADDR_LSB  = 0;
    localparam int LOAD_VALUE_LSB = LOAD_ADDR_LSB + ADDR_W;
    localparam int POS_LSB        = LOAD_VALUE_LSB + WORD_W;
    localparam int INFL_LSB       = POS_LSB + 3 * WORD_W;
    localparam int S_FIELDS_W     = INFL_LSB + INFLUENCES * INFL_W;
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = 3 * WORD_W;

    // Pipeline arithmetic widths
    localparam int PROD_W = 2 * WORD_W - 16;    // floored Q32.16 product
    localparam int SUM_W  = 50;                 // exact sums before saturation
    localparam int WPROD_W = WORD_W + WEIGHT_W; // row value times weight

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(8192);

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_VERTEX = 1'b1
    } action_t;

    typedef logic [WORD_W-1:0] word_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sd2147483647);
        lo = -SUM_W'(64'sd2147483648);
        if (v > hi) begin
            sat32 = hi[WORD_W-1:0];
        end else if (v < lo) begin
            sat32 = lo[WORD_W-1:0];
        end else begin
            sat32 = v[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/four_bone_vertex_skinning.sv -----
// Path: a vertex goes through stages 1 to 6, then the output register, to m_tdata.
// Throughput: one load or vertex per cycle while unstalled; loads produce no result.
// Backpressure: each stage advances when it is empty or its successor advances,
// so bubbles are squeezed out and a stall drops or repeats nothing.
// Reset (aresetn low, synchronous): clears all valid bits; the bone table is not
// cleared and holds unknown contents until written.
`default_nettype none

module four_bone_vertex_skinning (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // load_address, load_value, pos_x, pos_y, pos_z,
    // influence_a, influence_b, influence_c, influence_d, zero padding
    input  wire  [fbvs_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  wire  [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // skinned_x, skinned_y, skinned_z
    output logic [fbvs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fbvs_pkg::*;

    // ------------------------------------------------------------------
    // Input field extraction
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  in_addr;
    word_t              in_value;
    word_t              in_pos [3];
    logic [INFL_W-1:0]  in_infl [INFLUENCES];
    logic               in_accept;
    action_t            in_action;

    assign in_addr   = s_tdata[LOAD_ADDR_LSB +: ADDR_W];
    assign in_value  = s_tdata[LOAD_VALUE_LSB +: WORD_W];
    assign in_action = action_t'(s_tuser[0]);
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            in_pos[c] = s_tdata[POS_LSB + c * WORD_W +: WORD_W];
        end
        for (int k = 0; k < INFLUENCES; k++) begin
            in_infl[k] = s_tdata[INFL_LSB + k * INFL_W +: INFL_W];
        end
    end

    // ------------------------------------------------------------------
    // Handshake: stage enables ripple back from the output register.
    // A stage may load when it holds nothing or when its content moves on.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_tvalid_reg;
    logic en1, en2, en3, en4, en5, en6, en_out;

    assign en_out   = !m_tvalid_reg || m_tready;
    assign en6      = !v6_reg || en_out;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = m_tvalid_reg;

    // ------------------------------------------------------------------
    // Load address decode: word address = bone*12 + row*4 + col.
    // addr/12 = (addr>>2)/3, and (n*171)>>9 equals n/3 for every 8-bit n.
    // ------------------------------------------------------------------
    logic [7:0]        addr_quad;
    logic [15:0]       div3_prod;
    logic [6:0]        wr_bone_full;
    logic [8:0]        wr_rem_wide;
    logic [3:0]        wr_word;
    logic [BONE_W-1:0] wr_bone;
    logic              wr_in_range;
    logic              wr_en;

    assign addr_quad    = in_addr[ADDR_W-1:2];
    assign div3_prod    = 16'(addr_quad) * 16'd171;
    assign wr_bone_full = div3_prod[15:9];
    assign wr_rem_wide  = 9'(addr_quad) - 9'(wr_bone_full) * 9'd3;
    assign wr_word      = {wr_rem_wide[1:0], in_addr[1:0]};
    assign wr_bone      = BONE_W'(wr_bone_full);
    assign wr_in_range  = 32'(in_addr) < TABLE_WORDS;
    assign wr_en        = in_accept && (in_action == ACT_LOAD) && wr_in_range;

    // ------------------------------------------------------------------
    // Read side: one table copy per influence, each split into twelve
    // banks (one per matrix word), so all 48 words of a vertex are read in
    // the same cycle. Out-of-range bones read entry zero and get weight zero.
    // ------------------------------------------------------------------
    logic [BONE_W-1:0]   rd_bone [INFLUENCES];
    logic                bone_ok [INFLUENCES];
    logic [WEIGHT_W-1:0] in_weight [INFLUENCES];

    always_comb begin
        for (int k = 0; k < INFLUENCES; k++) begin
            bone_ok[k]   = 32'(in_infl[k][INFL_W-1:WEIGHT_W]) < NUM_BONES;
            rd_bone[k]   = bone_ok[k] ? BONE_W'(in_infl[k][INFL_W-1:WEIGHT_W]) : '0;
            in_weight[k] = bone_ok[k] ? in_infl[k][WEIGHT_W-1:0] : '0;
        end
    end

    // Stage 1: table read data, position and effective weights
    word_t mat1 [INFLUENCES][WORDS_PER_BONE];

    for (genvar gk = 0; gk < INFLUENCES; gk++) begin : g_copy
        for (genvar gw = 0; gw < WORDS_PER_BONE; gw++) begin : g_bank
            word_t bank_mem [NUM_BONES];
            word_t rd_reg;

            always_ff @(posedge aclk) begin
                if (wr_en && (wr_word == 4'(gw))) begin
                    bank_mem[wr_bone] <= in_value;
                end
            end

            // Read on the accept edge; a load accepted in the previous cycle is already visible.
            always_ff @(posedge aclk) begin
                if (en1) begin
                    rd_reg <= bank_mem[rd_bone[gk]];
                end
            end

            assign mat1[gk][gw] = rd_reg;
        end
    end

    logic signed [WORD_W-1:0] pos1_reg [3];
    logic [WEIGHT_W-1:0]      wgt1_reg [INFLUENCES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= in_accept && (in_action == ACT_VERTEX);
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int c = 0; c < 3; c++) begin
                pos1_reg[c] <= in_pos[c];
            end
            for (int k = 0; k < INFLUENCES; k++) begin
                wgt1_reg[k] <= in_weight[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: 36 floored Q32.16 products, matrix word by coordinate, both Q16.16
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod2_next [INFLUENCES][ROWS][COLS];
    logic signed [PROD_W-1:0] prod2_reg  [INFLUENCES][ROWS][COLS];
    logic signed [WORD_W-1:0] off2_reg   [INFLUENCES][ROWS];
    logic [WEIGHT_W-1:0]      wgt2_reg   [INFLUENCES];

    always_comb begin
        logic signed [2*WORD_W-1:0] full;
        for (int k = 0; k < INFLUENCES; k++) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    full = $signed(mat1[k][r*4+c]) * pos1_reg[c];
                    // Dropping the low 16 bits of a two's complement value floors it.
                    prod2_next[k][r][c] = full[2*WORD_W-1:16];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            for (int k = 0; k < INFLUENCES; k++) begin
                wgt2_reg[k] <= wgt1_reg[k];
                for (int r = 0; r < ROWS; r++) begin
                    off2_reg[k][r] <= mat1[k][r*4+3];
                    for (int c = 0; c < COLS; c++) begin
                        prod2_reg[k][r][c] <= prod2_next[k][r][c];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: exact row sums (three products plus translation column)
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] dot3_next [INFLUENCES][ROWS];
    logic signed [SUM_W-1:0] dot3_reg  [INFLUENCES][ROWS];
    logic [WEIGHT_W-1:0]     wgt3_reg  [INFLUENCES];

    always_comb begin
        for (int k = 0; k < INFLUENCES; k++) begin
            for (int r = 0; r < ROWS; r++) begin
                dot3_next[k][r] = SUM_W'(prod2_reg[k][r][0]) + SUM_W'(prod2_reg[k][r][1])
                                + SUM_W'(prod2_reg[k][r][2]) + SUM_W'(off2_reg[k][r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            for (int k = 0; k < INFLUENCES; k++) begin
                wgt3_reg[k] <= wgt2_reg[k];
                for (int r = 0; r < ROWS; r++) begin
                    dot3_reg[k][r] <= dot3_next[k][r];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: saturate each row value to Q16.16
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] row4_reg [INFLUENCES][ROWS];
    logic [WEIGHT_W-1:0]      wgt4_reg [INFLUENCES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            for (int k = 0; k < INFLUENCES; k++) begin
                wgt4_reg[k] <= wgt3_reg[k];
                for (int r = 0; r < ROWS; r++) begin
                    row4_reg[k][r] <= sat32(dot3_reg[k][r]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: scale each row value by its Q2.14 weight (exact Q18.30)
    // ------------------------------------------------------------------
    logic signed [WPROD_W-1:0] wp5_next [INFLUENCES][ROWS];
    logic signed [WPROD_W-1:0] wp5_reg  [INFLUENCES][ROWS];

    always_comb begin
        logic signed [WPROD_W:0] full;
        for (int k = 0; k < INFLUENCES; k++) begin
            for (int r = 0; r < ROWS; r++) begin
                full = row4_reg[k][r] * $signed({1'b0, wgt4_reg[k]});
                wp5_next[k][r] = full[WPROD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            for (int k = 0; k < INFLUENCES; k++) begin
                for (int r = 0; r < ROWS; r++) begin
                    wp5_reg[k][r] <= wp5_next[k][r];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: blend the four influences and add the rounding half
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] acc6_next [ROWS];
    logic signed [SUM_W-1:0] acc6_reg  [ROWS];

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            acc6_next[r] = SUM_W'(wp5_reg[0][r]) + SUM_W'(wp5_reg[1][r])
                         + SUM_W'(wp5_reg[2][r]) + SUM_W'(wp5_reg[3][r]) + ROUND_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en6) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en6) begin
            for (int r = 0; r < ROWS; r++) begin
                acc6_reg[r] <= acc6_next[r];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: floor to Q16.16, saturate, hold until taken
    // ------------------------------------------------------------------
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    always_comb begin
        logic signed [SUM_W-1:0] shifted;
        for (int r = 0; r < ROWS; r++) begin
            shifted = acc6_reg[r] >>> 14;
            m_tdata_next[r*WORD_W +: WORD_W] = sat32(shifted);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

// ----- rtl/fbvs_checker.sv -----
`default_nettype none

module fbvs_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_tvalid,
    input wire                             s_tready,
    input wire [0:0]                       s_tuser,
    input wire                             m_tvalid,
    input wire                             m_tready,
    input wire [fbvs_pkg::M_TDATA_W-1:0]   m_tdata
);
    import fbvs_pkg::*;

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Input side only stalls when a result is held at the output
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A held result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // No result arrives after an idle stretch begun with an empty output
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !(s_tvalid && s_tready)) ##1 (!(s_tvalid && s_tready))
        ##1 (!(s_tvalid && s_tready)) ##1 (!(s_tvalid && s_tready))
        ##1 (!(s_tvalid && s_tready)) ##1 (!(s_tvalid && s_tready))
        ##1 (!(s_tvalid && s_tready) && $past(s_tuser[0], 7) == ACT_LOAD
             && $past(!(s_tvalid && s_tready) || !aresetn, 7))
        |=> !m_tvalid || $past(m_tvalid))
        else $error("result with no vertex accepted");

endmodule

bind four_bone_vertex_skinning fbvs_checker u_fbvs_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import fbvs_pkg::*;

    localparam int INFL_BUS_W   = INFLUENCES * INFL_W;
    localparam int TARGET_ITEMS = 1100;
    // Allow generous slack after the last result
    localparam int SETTLE_CYCLES = 20;
    // Slowest correct run stalls only for short random gaps plus the pipeline drain time;
    // a run of STALL_LIMIT quiet cycles means the block has hung
    localparam int STALL_LIMIT = 2000;

    // One input transaction as queued for the driver
    typedef struct {
        action_t                 act;
        logic [ADDR_W-1:0]       load_address;
        logic [WORD_W-1:0]       load_value;
        logic [WORD_W-1:0]       pos_x;
        logic [WORD_W-1:0]       pos_y;
        logic [WORD_W-1:0]       pos_z;
        logic [INFL_BUS_W-1:0]   infl;       // influence_a in the lowest bits
        bit                      wait_idle;  // hold off until every result is back
    } skin_txn_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]             s_tuser  = ACT_LOAD;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // Pending input transactions, filled once at time zero
    skin_txn_t              stim_q[$];
    // Skinned positions still owed by the block, oldest first
    logic [M_TDATA_W-1:0]   skinned_q[$];

    // Predictor copy of the bone matrix table
    logic signed [WORD_W-1:0] bone_words [TABLE_WORDS];

    // Generator bookkeeping: which words have been written, and which bones are complete
    bit                     word_seen [TABLE_WORDS];
    bit                     bone_ready [NUM_BONES];
    int                     ready_bones[$];
    int                     stim_count = 0;

    logic                   s_fire = 1'b0;
    int                     items_sent = 0;
    int                     errors = 0;
    int                     quiet_cycles = 0;

    // Stretch of the run with no random idling on either side
    wire calm_window = (items_sent >= 400) && (items_sent < 650);

    four_bone_vertex_skinning i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Blend the position through up to four bone matrices; x, y, z packed lowest first
    function automatic logic [M_TDATA_W-1:0] blend_vertex(
        logic signed [WORD_W-1:0] px,
        logic signed [WORD_W-1:0] py,
        logic signed [WORD_W-1:0] pz,
        logic [INFL_BUS_W-1:0]    infl
    );
        longint                 coord [3];
        longint                 acc [3];
        longint                 dot;
        longint                 weight;
        int                     bone;
        int                     base;
        logic [M_TDATA_W-1:0]   res;
        coord[0] = px;
        coord[1] = py;
        coord[2] = pz;
        for (int r = 0; r < ROWS; r++)
            acc[r] = 0;
        for (int k = 0; k < INFLUENCES; k++) begin
            bone   = infl[k*INFL_W + WEIGHT_W +: INDEX_W];
            weight = infl[k*INFL_W +: WEIGHT_W];
            // an index past the table adds nothing
            if (bone < NUM_BONES) begin
                base = bone * WORDS_PER_BONE;
                for (int r = 0; r < ROWS; r++) begin
                    dot = bone_words[base + r*4 + 3];
                    for (int c = 0; c < COLS; c++)
                        dot += (longint'(bone_words[base + r*4 + c]) * coord[c]) >>> 16;
                    acc[r] += clamp_word(dot) * weight;
                end
            end
        end
        for (int r = 0; r < ROWS; r++)
            res[r*WORD_W +: WORD_W] = WORD_W'(clamp_word((acc[r] + 8192) >>> 14));
        return res;
    endfunction

    // Random Q16.16 value: mostly within +-span, sometimes the extremes or any pattern
    function automatic logic [WORD_W-1:0] rand_fixed(int unsigned span);
        case ($urandom_range(0, 11))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom();
            default: return $urandom_range(0, 2*span - 1) - span;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 16'h4000;
            3: return WEIGHT_W'($urandom());
            default: return WEIGHT_W'($urandom_range(0, 16'h4000));
        endcase
    endfunction

    function automatic logic [INFL_W-1:0] make_influence(int bone, logic [WEIGHT_W-1:0] weight);
        return {INDEX_W'(bone), weight};
    endfunction

    // Queue a matrix word write; ignored fields carry noise
    task automatic push_load(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] value);
        skin_txn_t t;
        int        bone;
        bit        full;
        t.act          = ACT_LOAD;
        t.load_address = addr;
        t.load_value   = value;
        t.pos_x        = $urandom();
        t.pos_y        = $urandom();
        t.pos_z        = $urandom();
        t.infl         = INFL_BUS_W'({$urandom(), $urandom(), $urandom()});
        t.wait_idle    = 1'b0;
        stim_q.push_back(t);
        stim_count++;
        if (addr < TABLE_WORDS) begin
            word_seen[addr] = 1'b1;
            bone = addr / WORDS_PER_BONE;
            if (!bone_ready[bone]) begin
                full = 1'b1;
                for (int w = 0; w < WORDS_PER_BONE; w++)
                    full &= word_seen[bone*WORDS_PER_BONE + w];
                if (full) begin
                    bone_ready[bone] = 1'b1;
                    ready_bones.push_back(bone);
                end
            end
        end
    endtask

    task automatic push_vertex(logic [WORD_W-1:0] px, logic [WORD_W-1:0] py,
                               logic [WORD_W-1:0] pz, logic [INFL_BUS_W-1:0] infl,
                               bit hold);
        skin_txn_t t;
        t.act          = ACT_VERTEX;
        t.load_address = ADDR_W'($urandom());
        t.load_value   = $urandom();
        t.pos_x        = px;
        t.pos_y        = py;
        t.pos_z        = pz;
        t.infl         = infl;
        t.wait_idle    = hold;
        stim_q.push_back(t);
        stim_count++;
    endtask

    // Write all twelve words of one bone with random content
    task automatic load_bone(int bone);
        for (int w = 0; w < WORDS_PER_BONE; w++)
            push_load(ADDR_W'(bone*WORDS_PER_BONE + w), rand_fixed(32'h0002_0000));
    endtask

    // Stimulus, then the end-of-run wait and verdict
    initial begin : stimulus
        logic [WORD_W-1:0]      shift_col [3];
        logic [INFL_BUS_W-1:0]  infl;
        int                     pick;
        shift_col[0] = 32'h7FFF_FFFF;
        shift_col[1] = 32'h8000_0000;
        shift_col[2] = 32'h0001_8000;

        // Bone 0: identity rotation, x and y translations at the word extremes
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < 4; c++)
                push_load(ADDR_W'(r*4 + c), (c == r) ? 32'h0001_0000 :
                                            (c == 3) ? shift_col[r] : 32'h0);

        // Single influence at weight one: the x row saturates against its translation
        push_vertex(32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                    {make_influence(0, 0), make_influence(0, 0),
                     make_influence(0, 0), make_influence(0, 16'h4000)}, 1'b0);
        // Extreme coordinates and the largest weights: the blended sum saturates
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    {4{make_influence(0, 16'hFFFF)}}, 1'b0);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    {4{make_influence(0, 16'h4000)}}, 1'b0);
        // All weights zero, sent only once every earlier result is back
        push_vertex(32'h0, 32'h0, 32'h0, {4{make_influence(0, 0)}}, 1'b1);
        // Two half weights, rounding on a fractional position
        push_vertex(32'h0000_8000, 32'hFFFF_C000, 32'h0007_0000,
                    {make_influence(0, 0), make_influence(0, 0),
                     make_influence(0, 16'h2000), make_influence(0, 16'h2000)}, 1'b0);
        // Writes past the table leave it untouched
        push_load(ADDR_W'(TABLE_WORDS), $urandom());
        push_load('1, $urandom());
        // Overwrite live words, then use them straight away
        push_load(ADDR_W'(3), 32'h0000_8000);
        push_load(ADDR_W'(0), 32'hFFFF_0000);
        push_vertex(rand_fixed(32'h0100_0000), rand_fixed(32'h0100_0000),
                    rand_fixed(32'h0100_0000),
                    {make_influence(0, 0), make_influence(0, 16'h1000),
                     make_influence(0, 0), make_influence(0, 16'h4000)}, 1'b0);

        // Random part: bone uploads with random content, vertices over complete bones,
        // and stray single-word writes anywhere in the address space
        load_bone(NUM_BONES - 1);
        while (stim_count < TARGET_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                load_bone($urandom_range(0, NUM_BONES - 1));
            end else if (pick < 20) begin
                push_load(ADDR_W'($urandom()), rand_fixed(32'h0002_0000));
            end else begin
                for (int k = 0; k < INFLUENCES; k++)
                    infl[k*INFL_W +: INFL_W] = make_influence(
                        ready_bones[$urandom_range(0, ready_bones.size() - 1)], rand_weight());
                // now and then hold the sender off until the pipeline has emptied
                push_vertex(rand_fixed(32'h0100_0000), rand_fixed(32'h0100_0000),
                            rand_fixed(32'h0100_0000), infl, $urandom_range(0, 99) == 0);
            end
        end

        // Release reset on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every transaction to go in, then for every result to come out
        do
            @(posedge aclk);
        while (stim_q.size() != 0 || s_tvalid);
        while (skinned_q.size() != 0)
            @(posedge aclk);
        // Watch a little longer for stray results
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Driver: present the next transaction at the falling edge once the current one is taken
    always @(negedge aclk) begin : drive_input
        skin_txn_t t;
        logic [S_TDATA_W-1:0] d;
        // hold a transaction that the block has not yet taken
        if (aresetn && !(s_tvalid && !s_fire)) begin
            if (stim_q.size() != 0
                && !(stim_q[0].wait_idle && skinned_q.size() != 0)
                && (calm_window || $urandom_range(0, 99) >= 10)) begin
                t = stim_q.pop_front();
                d = '0;
                d[LOAD_ADDR_LSB  +: ADDR_W]     = t.load_address;
                d[LOAD_VALUE_LSB +: WORD_W]     = t.load_value;
                d[POS_LSB            +: WORD_W] = t.pos_x;
                d[POS_LSB + WORD_W   +: WORD_W] = t.pos_y;
                d[POS_LSB + 2*WORD_W +: WORD_W] = t.pos_z;
                d[INFL_LSB +: INFL_BUS_W]       = t.infl;
                s_tdata    <= d;
                s_tuser    <= t.act;
                s_tvalid   <= 1'b1;
                items_sent <= items_sent + 1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure
    always @(negedge aclk) begin
        m_tready <= calm_window || ($urandom_range(0, 99) >= 10);
    end

    // Monitor: update the predictor on each input transaction, check each result
    always @(posedge aclk) begin : monitor
        logic [ADDR_W-1:0]    addr;
        logic [M_TDATA_W-1:0] want;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            if (action_t'(s_tuser) == ACT_LOAD) begin
                addr = s_tdata[LOAD_ADDR_LSB +: ADDR_W];
                // drop writes past the table
                if (addr < TABLE_WORDS)
                    bone_words[addr] = s_tdata[LOAD_VALUE_LSB +: WORD_W];
            end else begin
                skinned_q.push_back(blend_vertex(s_tdata[POS_LSB +: WORD_W],
                                                 s_tdata[POS_LSB + WORD_W +: WORD_W],
                                                 s_tdata[POS_LSB + 2*WORD_W +: WORD_W],
                                                 s_tdata[INFL_LSB +: INFL_BUS_W]));
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (skinned_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = skinned_q.pop_front();
                for (int f = 0; f < 3; f++)
                    if (m_tdata[f*WORD_W +: WORD_W] !== want[f*WORD_W +: WORD_W])
                        report_mismatch($sformatf("skinned_%s got %h want %h",
                                        f == 0 ? "x" : (f == 1 ? "y" : "z"),
                                        m_tdata[f*WORD_W +: WORD_W],
                                        want[f*WORD_W +: WORD_W]));
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] TIMEOUT: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ----- files.f -----
rtl/fbvs_pkg.sv
rtl/four_bone_vertex_skinning.sv
rtl/fbvs_checker.sv
tb/tb.sv
